// File: sv/sptsi_pkg.sv
// sptsi_pkg: shared types and codes for the sorted pair table search/insert block
// holds the item and result beat structs, the stored pair type and the sequencer states
// no dependencies
package sptsi_pkg;

    localparam int POS_W  = 11;
    localparam int COPY_W = 9;
    localparam int KEY_W  = 32;
    localparam int PAIR_W = 2 * KEY_W;

    localparam logic       KIND_SEARCH = 1'b0;
    localparam logic       KIND_INSERT = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_REJECT    = 2'd2;

    typedef logic [PAIR_W-1:0] pair_t;

    typedef struct packed {
        logic                    kind;
        logic [KEY_W-1:0]        key_id;
        logic signed [KEY_W-1:0] source_button;
        logic [POS_W-1:0]        position;
        logic [COPY_W-1:0]       copies;
    } item_beat_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] result_position;
    } result_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SRCH_CMP,
        ST_INS_CHK,
        ST_INS_LO,
        ST_INS_HI,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FILL
    } state_t;

endpackage

// File: sv/sorted_pair_table_search_insert.sv
// sorted_pair_table_search_insert: table kept sorted by (key_id, source_button), shared comparator
// binary search and insert with shift under a sequencer; depends on sptsi_pkg and sptsi_ram
// search: each halving step reads the middle entry, then compares; result once the range is empty
// insert: checks, a read and a write per shifted entry, a write per copy, then the result strobe
// one item at a time; busy high until the result strobe, which the receiver cannot stall
// reset clears the entry count and the sequencer; table contents stay undefined until written
module sorted_pair_table_search_insert #(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_COPIES  = 256
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  sptsi_pkg::item_beat_t    item,
    output logic                     busy,
    output logic                     done,
    output sptsi_pkg::result_beat_t  result
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W  = ((CNT_W > sptsi_pkg::POS_W) ? CNT_W : sptsi_pkg::POS_W) + 1;
    localparam logic [IDX_W-1:0] DEPTH_LIM  = IDX_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] COPIES_LIM = IDX_W'(MAX_COPIES);

    sptsi_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             lo_reg, lo_next;
    logic [CNT_W-1:0]             hi_reg, hi_next;
    logic [CNT_W-1:0]             mid_reg, mid_next;
    logic                         found_reg, found_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    sptsi_pkg::pair_t             pair_reg, pair_next;
    logic [IDX_W-1:0]             pos_reg, pos_next;
    logic [sptsi_pkg::COPY_W-1:0] copies_reg, copies_next;
    logic                         done_reg, done_next;
    sptsi_pkg::result_beat_t      result_reg, result_next;

    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    sptsi_pkg::pair_t             wr_data;
    logic [ADDR_W-1:0]            rd_addr;
    sptsi_pkg::pair_t             rd_data;

    logic [CNT_W-1:0]             mid;
    logic [IDX_W-1:0]             count_ext;
    logic [IDX_W-1:0]             copies_ext;
    logic                         cmp_lt;
    logic                         cmp_eq;
    logic                         search_go;
    logic                         chk_reject;
    logic                         has_lo;
    logic                         has_hi;
    logic                         lo_break;
    logic                         hi_break;
    logic                         shift_go;
    logic                         fill_last;

    sptsi_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shared comparator
    assign cmp_lt = rd_data < pair_reg;
    assign cmp_eq = rd_data == pair_reg;

    assign mid        = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign count_ext  = IDX_W'(count_reg);
    assign copies_ext = IDX_W'(copies_reg);
    assign search_go  = lo_reg < hi_reg;
    assign chk_reject = (pos_reg > count_ext)
                     || (copies_reg == '0)
                     || (copies_ext > COPIES_LIM)
                     || ((count_ext + copies_ext) > DEPTH_LIM);
    assign has_lo     = pos_reg != '0;
    assign has_hi     = pos_reg < count_ext;
    assign lo_break   = !cmp_lt && !cmp_eq;
    assign hi_break   = cmp_lt;
    assign shift_go   = idx_reg > pos_reg;
    assign fill_last  = (idx_reg + IDX_W'(1)) == copies_ext;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sptsi_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (item.kind == sptsi_pkg::KIND_INSERT) ? sptsi_pkg::ST_INS_CHK
                                                                         : sptsi_pkg::ST_SRCH;
                end
            end
            sptsi_pkg::ST_SRCH:
            begin
                state_next = search_go ? sptsi_pkg::ST_SRCH_CMP : sptsi_pkg::ST_IDLE;
            end
            sptsi_pkg::ST_SRCH_CMP:
            begin
                state_next = sptsi_pkg::ST_SRCH;
            end
            sptsi_pkg::ST_INS_CHK:
            begin
                priority if (chk_reject)
                begin
                    state_next = sptsi_pkg::ST_IDLE;
                end
                else if (has_lo)
                begin
                    state_next = sptsi_pkg::ST_INS_LO;
                end
                else if (has_hi)
                begin
                    state_next = sptsi_pkg::ST_INS_HI;
                end
                else
                begin
                    state_next = sptsi_pkg::ST_SHIFT_RD;
                end
            end
            sptsi_pkg::ST_INS_LO:
            begin
                priority if (lo_break)
                begin
                    state_next = sptsi_pkg::ST_IDLE;
                end
                else if (has_hi)
                begin
                    state_next = sptsi_pkg::ST_INS_HI;
                end
                else
                begin
                    state_next = sptsi_pkg::ST_SHIFT_RD;
                end
            end
            sptsi_pkg::ST_INS_HI:
            begin
                state_next = hi_break ? sptsi_pkg::ST_IDLE : sptsi_pkg::ST_SHIFT_RD;
            end
            sptsi_pkg::ST_SHIFT_RD:
            begin
                state_next = shift_go ? sptsi_pkg::ST_SHIFT_WR : sptsi_pkg::ST_FILL;
            end
            sptsi_pkg::ST_SHIFT_WR:
            begin
                state_next = sptsi_pkg::ST_SHIFT_RD;
            end
            sptsi_pkg::ST_FILL:
            begin
                state_next = fill_last ? sptsi_pkg::ST_IDLE : sptsi_pkg::ST_FILL;
            end
            default:
            begin
                state_next = sptsi_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        found_next  = found_reg;
        idx_next    = idx_reg;
        pair_next   = pair_reg;
        pos_next    = pos_reg;
        copies_next = copies_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = pair_reg;
        rd_addr     = '0;
        unique case (state_reg)
            sptsi_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    pair_next   = {item.key_id, item.source_button ^ 32'h8000_0000};
                    pos_next    = IDX_W'(item.position);
                    copies_next = item.copies;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    found_next  = 1'b0;
                end
            end
            sptsi_pkg::ST_SRCH:
            begin
                rd_addr  = ADDR_W'(mid);
                mid_next = mid;
                if (!search_go)
                begin
                    done_next                   = 1'b1;
                    result_next.status          = found_reg ? sptsi_pkg::STATUS_OK
                                                            : sptsi_pkg::STATUS_NOT_FOUND;
                    result_next.result_position = sptsi_pkg::POS_W'(lo_reg);
                end
            end
            sptsi_pkg::ST_SRCH_CMP:
            begin
                if (cmp_lt)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next    = mid_reg;
                    found_next = cmp_eq;
                end
            end
            sptsi_pkg::ST_INS_CHK:
            begin
                priority if (chk_reject)
                begin
                    done_next                   = 1'b1;
                    result_next.status          = sptsi_pkg::STATUS_REJECT;
                    result_next.result_position = sptsi_pkg::POS_W'(pos_reg);
                end
                else if (has_lo)
                begin
                    rd_addr = ADDR_W'(pos_reg - IDX_W'(1));
                end
                else if (has_hi)
                begin
                    rd_addr = ADDR_W'(pos_reg);
                end
                else
                begin
                    idx_next = count_ext;
                end
            end
            sptsi_pkg::ST_INS_LO:
            begin
                priority if (lo_break)
                begin
                    done_next                   = 1'b1;
                    result_next.status          = sptsi_pkg::STATUS_REJECT;
                    result_next.result_position = sptsi_pkg::POS_W'(pos_reg);
                end
                else if (has_hi)
                begin
                    rd_addr = ADDR_W'(pos_reg);
                end
                else
                begin
                    idx_next = count_ext;
                end
            end
            sptsi_pkg::ST_INS_HI:
            begin
                if (hi_break)
                begin
                    done_next                   = 1'b1;
                    result_next.status          = sptsi_pkg::STATUS_REJECT;
                    result_next.result_position = sptsi_pkg::POS_W'(pos_reg);
                end
                else
                begin
                    idx_next = count_ext;
                end
            end
            sptsi_pkg::ST_SHIFT_RD:
            begin
                if (shift_go)
                begin
                    rd_addr = ADDR_W'(idx_reg - IDX_W'(1));
                end
                else
                begin
                    idx_next = '0;
                end
            end
            sptsi_pkg::ST_SHIFT_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = ADDR_W'(idx_reg - IDX_W'(1) + copies_ext);
                wr_data  = rd_data;
                idx_next = idx_reg - IDX_W'(1);
            end
            sptsi_pkg::ST_FILL:
            begin
                wr_en    = 1'b1;
                wr_addr  = ADDR_W'(pos_reg + idx_reg);
                wr_data  = pair_reg;
                idx_next = idx_reg + IDX_W'(1);
                if (fill_last)
                begin
                    count_next                  = CNT_W'(count_ext + copies_ext);
                    done_next                   = 1'b1;
                    result_next.status          = sptsi_pkg::STATUS_OK;
                    result_next.result_position = sptsi_pkg::POS_W'(pos_reg);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sptsi_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        found_reg  <= found_next;
        idx_reg    <= idx_next;
        pair_reg   <= pair_next;
        pos_reg    <= pos_next;
        copies_reg <= copies_next;
        result_reg <= result_next;
    end

    assign busy   = state_reg != sptsi_pkg::ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: sv/sptsi_ram.sv
// sptsi_ram: single write port, single read port table memory with registered read data
// depends on sptsi_pkg for the stored pair type
module sptsi_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  sptsi_pkg::pair_t    wr_data,
    input  logic [ADDR_W-1:0]   rd_addr,
    output sptsi_pkg::pair_t    rd_data
);

    sptsi_pkg::pair_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
